// ===== hdl/hrlp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrlp_pkg
// Types, codes and character tables shared by the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    localparam int URL_LEN_W = 13;
    localparam int OUT_DEPTH = 4;
    localparam int VERSION_LEN = 10;

    // result kinds
    localparam logic KIND_URL     = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // method codes
    localparam logic [1:0] METH_GET    = 2'd0;
    localparam logic [1:0] METH_POST   = 2'd1;
    localparam logic [1:0] METH_PUT    = 2'd2;
    localparam logic [1:0] METH_DELETE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_METHOD  = 2'd1;
    localparam logic [1:0] ST_BAD_URL     = 2'd2;
    localparam logic [1:0] ST_BAD_VERSION = 2'd3;

    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_G   = 8'h47;
    localparam logic [7:0] CHAR_P   = 8'h50;
    localparam logic [7:0] CHAR_D   = 8'h44;
    localparam logic [7:0] CHAR_O   = 8'h4F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_t;

    typedef struct packed {
        logic                 kind;
        logic [7:0]           url_byte;
        logic [1:0]           method;
        logic [1:0]           status;
        logic [URL_LEN_W-1:0] url_length;
        logic                 last_of_run;
    } out_t;

    function automatic logic [3:0] method_len(input logic [1:0] meth);
        logic [3:0] len;
        unique case (meth)
            METH_GET:    len = 4'd3;
            METH_POST:   len = 4'd4;
            METH_PUT:    len = 4'd3;
            METH_DELETE: len = 4'd6;
            default:     len = 4'd3;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] method_char(input logic [1:0] meth, input logic [3:0] pos);
        logic [47:0] text;
        logic [7:0]  c;
        unique case (meth)
            METH_GET:    text = {"GET", 24'h0};
            METH_POST:   text = {"POST", 16'h0};
            METH_PUT:    text = {"PUT", 24'h0};
            METH_DELETE: text = "DELETE";
            default:     text = 48'h0;
        endcase
        case (pos)
            4'd0:    c = text[47:40];
            4'd1:    c = text[39:32];
            4'd2:    c = text[31:24];
            4'd3:    c = text[23:16];
            4'd4:    c = text[15:8];
            4'd5:    c = text[7:0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] version_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h48; // H
            4'd1:    c = 8'h54; // T
            4'd2:    c = 8'h54; // T
            4'd3:    c = 8'h50; // P
            4'd4:    c = 8'h2F; // /
            4'd5:    c = 8'h31; // 1
            4'd6:    c = 8'h2E; // .
            4'd7:    c = 8'h31; // 1
            4'd8:    c = 8'h0D; // CR
            4'd9:    c = 8'h0A; // LF
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/hrlp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// hrlp_out_fifo
// Small result queue: takes up to two results per cycle, hands out one per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module hrlp_out_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [1:0]     push_cnt,
    input  hrlp_pkg::out_t push_a,
    input  hrlp_pkg::out_t push_b,
    output logic           room_for_two,
    output logic           m_valid,
    input  logic           m_ready,
    output hrlp_pkg::out_t m_data
);
    import hrlp_pkg::*;

    localparam int PTR_W = $clog2(OUT_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    out_t             mem [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop;

    assign pop          = m_valid && m_ready;
    assign m_valid      = count_reg != '0;
    assign m_data       = mem[rd_ptr_reg];
    assign room_for_two = count_reg <= CNT_W'(OUT_DEPTH - 2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push_a;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push_b;
        end
    end

endmodule

// ===== hdl/http_request_line_parser.sv =====
// ----------------------------------------------------------------------------
// http_request_line_parser
// Results are written into a registered result queue and leave on m_ in order.
// Takes one byte per cycle while s_ready is high; a byte that yields two
// results (URL byte plus verdict) is drained through a four-entry result
// queue, which holds s_ready low while fewer than two entries are free.
// Reset: synchronous active-low aresetn returns to the method phase, empty queue.
// ----------------------------------------------------------------------------
module http_request_line_parser #(
    parameter int MAX_URL_BYTES = 4096
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  hrlp_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output hrlp_pkg::out_t m_data
);
    import hrlp_pkg::*;

    localparam int CNT_W = $clog2(MAX_URL_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_URL_BYTES);

    localparam logic [2:0] PH_METHOD  = 3'd0;
    localparam logic [2:0] PH_GAP1    = 3'd1;
    localparam logic [2:0] PH_URL     = 3'd2;
    localparam logic [2:0] PH_GAP2    = 3'd3;
    localparam logic [2:0] PH_VERSION = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    logic [2:0]       phase_reg, phase_next;
    logic [1:0]       guess_reg, guess_next;
    logic [3:0]       pos_reg, pos_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sent_reg, sent_next;

    logic             accept;
    logic             room_for_two;
    logic [7:0]       b;
    logic             is_gap;
    logic [1:0]       g2;
    logic [3:0]       vpos;
    logic             url_hit;
    logic             verd_hit;
    logic [1:0]       verd_status;
    logic [CNT_W+URL_LEN_W-1:0] len_ext;
    out_t             url_res;
    out_t             verd_res;
    out_t             push_a;
    out_t             push_b;
    logic [1:0]       push_cnt;

    assign s_ready = room_for_two;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.data_byte;
    assign is_gap  = (b == CHAR_SP) || (b == CHAR_TAB);

    always_comb begin
        phase_next  = phase_reg;
        guess_next  = guess_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        sent_next   = sent_reg;
        url_hit     = 1'b0;
        verd_hit    = 1'b0;
        verd_status = ST_OK;
        g2          = guess_reg;
        vpos        = pos_reg;

        unique case (phase_reg)
            PH_METHOD: begin
                if (is_gap) begin
                    if (pos_reg != 4'd0 && pos_reg == method_len(guess_reg)) begin
                        phase_next = PH_GAP1;
                    end else begin
                        verd_hit    = 1'b1;
                        verd_status = ST_BAD_METHOD;
                    end
                end else if (pos_reg == 4'd0) begin
                    pos_next = 4'd1;
                    if (b == CHAR_G) begin
                        guess_next = METH_GET;
                    end else if (b == CHAR_P) begin
                        guess_next = METH_PUT;
                    end else if (b == CHAR_D) begin
                        guess_next = METH_DELETE;
                    end else begin
                        pos_next    = pos_reg;
                        verd_hit    = 1'b1;
                        verd_status = ST_BAD_METHOD;
                    end
                end else begin
                    // second letter after P decides POST or PUT
                    if (pos_reg == 4'd1 && (guess_reg == METH_POST || guess_reg == METH_PUT)) begin
                        g2 = (b == CHAR_O) ? METH_POST : METH_PUT;
                    end
                    guess_next = g2;
                    if (pos_reg >= method_len(g2) || b != method_char(g2, pos_reg)) begin
                        verd_hit    = 1'b1;
                        verd_status = ST_BAD_METHOD;
                    end else begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
            end
            PH_GAP1, PH_URL: begin
                if (is_gap) begin
                    if (phase_reg == PH_URL) begin
                        phase_next = PH_GAP2;
                    end
                end else begin
                    phase_next = PH_URL;
                    url_hit    = 1'b1;
                    if (cnt_reg < CNT_MAX) begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            PH_GAP2, PH_VERSION: begin
                if (!(phase_reg == PH_GAP2 && is_gap)) begin
                    vpos       = (phase_reg == PH_GAP2) ? 4'd0 : pos_reg;
                    phase_next = PH_VERSION;
                    pos_next   = vpos;
                    if (vpos >= 4'(VERSION_LEN) || b != version_char(vpos)) begin
                        verd_hit    = 1'b1;
                        verd_status = ST_BAD_VERSION;
                    end else begin
                        pos_next = vpos + 4'd1;
                        if (vpos + 4'd1 == 4'(VERSION_LEN)) begin
                            verd_hit    = 1'b1;
                            verd_status = ST_OK;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        if (verd_hit) begin
            phase_next = PH_DONE;
            sent_next  = 1'b1;
        end

        // buffer ends without a verdict: close it out by where parsing stopped
        if (s_data.end_of_buffer) begin
            if (!sent_next) begin
                verd_hit = 1'b1;
                if (phase_next == PH_METHOD) begin
                    verd_status = (pos_next != 4'd0 && pos_next == method_len(guess_next))
                                  ? ST_BAD_URL : ST_BAD_METHOD;
                end else if (phase_next == PH_GAP1 || phase_next == PH_URL) begin
                    verd_status = ST_BAD_URL;
                end else begin
                    verd_status = ST_BAD_VERSION;
                end
            end
        end
    end

    assign len_ext = {{URL_LEN_W{1'b0}}, cnt_next};

    always_comb begin
        url_res             = '0;
        url_res.kind        = KIND_URL;
        url_res.url_byte    = b;
        url_res.last_of_run = !verd_hit;

        verd_res             = '0;
        verd_res.kind        = KIND_VERDICT;
        verd_res.method      = (verd_status == ST_BAD_METHOD) ? METH_GET : guess_next;
        verd_res.status      = verd_status;
        verd_res.url_length  = len_ext[URL_LEN_W-1:0];
        verd_res.last_of_run = 1'b1;

        push_a = url_hit ? url_res : verd_res;
        push_b = verd_res;
        if (!accept) begin
            push_cnt = 2'd0;
        end else begin
            push_cnt = 2'(url_hit) + 2'(verd_hit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_METHOD;
            guess_reg <= '0;
            pos_reg   <= '0;
            cnt_reg   <= '0;
            sent_reg  <= 1'b0;
        end else if (accept) begin
            if (s_data.end_of_buffer) begin
                phase_reg <= PH_METHOD;
                guess_reg <= '0;
                pos_reg   <= '0;
                cnt_reg   <= '0;
                sent_reg  <= 1'b0;
            end else begin
                phase_reg <= phase_next;
                guess_reg <= guess_next;
                pos_reg   <= pos_next;
                cnt_reg   <= cnt_next;
                sent_reg  <= sent_next;
            end
        end
    end

    hrlp_out_fifo u_out_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push_cnt     (push_cnt),
        .push_a       (push_a),
        .push_b       (push_b),
        .room_for_two (room_for_two),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule
